// ===== rtl/fdd_pkg.sv =====
// Shared types and constants for the first-duplicate detector.
// No dependencies.
package fdd_pkg;

  localparam int unsigned VALUE_W = 11;
  localparam int unsigned EPOCH_W = 8;

  typedef logic [VALUE_W-1:0] value_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  // Epoch zero marks an entry as empty; live sets use the other codes.
  localparam epoch_t EPOCH_NONE  = '0;
  localparam epoch_t EPOCH_FIRST = epoch_t'(1);
  localparam epoch_t EPOCH_LAST  = '1;

endpackage

// ===== rtl/first_duplicate_detector.sv =====
// First-duplicate detector: epoch-tagged seen map in a synchronous RAM.
// Depends on fdd_pkg.
// Usage:
//   Input channel (in_valid_i/in_ready_o) carries one word per element:
//   value_i (1..MAX_VALUE) and last_i marking the final element of a set.
//   Output channel (out_valid_o/out_ready_i) carries at most one word per set:
//   found_o=1 with dup_value_o on the first repeated value, or found_o=0 and
//   dup_value_o=0 on the last element when the set had no repeat.
//   Out-of-range values are ignored.
// Timing:
//   One element per cycle unless clearing, wrap hold or output back-pressure stalls it;
//   same-entry marks back to back are forwarded; the RAM is read at the accepting edge.
// Reset and clearing:
//   Each RAM entry holds the set tag (epoch) that last marked it, so a set
//   ends by bumping the epoch instead of wiping the map. After reset, and
//   after every 255 sets when the epoch wraps, a clearing pass writes one
//   entry per cycle through all MAX_VALUE entries; in_ready_o is low meanwhile.
// Stalls:
//   While out_ready_i is low with a word pending, one more element is taken
//   and held; after that in_ready_o drops until the output drains.
module first_duplicate_detector #(
  parameter int unsigned MAX_VALUE = 1024
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [fdd_pkg::VALUE_W-1:0]   value_i,
  input  logic                          last_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          found_o,
  output logic [fdd_pkg::VALUE_W-1:0]   dup_value_o
);

  localparam int unsigned AW = $clog2(MAX_VALUE);

  typedef logic [AW-1:0] addr_t;

  localparam addr_t ADDR_END = addr_t'(MAX_VALUE - 1);

  // seen map: one epoch tag per value
  fdd_pkg::epoch_t mem [MAX_VALUE];
  fdd_pkg::epoch_t rd_q;

  // element stage (read data arrives here)
  logic            s_valid_q, s_valid_d;
  logic            s_last_q;
  logic            s_range_q;
  addr_t           s_addr_q;
  fdd_pkg::value_t s_value_q;
  logic            fwd_q;

  // set state
  fdd_pkg::epoch_t epoch_q, epoch_d;
  logic            answered_q, answered_d;

  // clearing pass
  logic            clr_q, clr_d;
  addr_t           clr_cnt_q, clr_cnt_d;

  // output register
  logic            out_valid_q, out_valid_d;
  logic            found_q, found_d;
  fdd_pkg::value_t dup_q, dup_d;

  logic            in_range;
  addr_t           in_addr;
  logic            in_acc;
  logic            proceed;
  logic            wrap_hold;
  logic            seen;
  logic            mark_we;
  logic            mem_we;
  addr_t           mem_waddr;
  fdd_pkg::epoch_t mem_wdata;

  assign in_range = (value_i != '0) && (32'(value_i) <= 32'(MAX_VALUE));
  assign in_addr  = addr_t'(value_i - fdd_pkg::value_t'(1));

  assign proceed   = s_valid_q && (!out_valid_q || out_ready_i);
  // an element behind a wrapping last word would see the old tags
  assign wrap_hold = s_valid_q && s_last_q && (epoch_q == fdd_pkg::EPOCH_LAST);
  assign in_ready_o = !clr_q && !wrap_hold && (!s_valid_q || proceed);
  assign in_acc     = in_valid_i && in_ready_o;

  assign seen    = fwd_q || (rd_q == epoch_q);
  assign mark_we = proceed && !answered_q && s_range_q && !seen && !s_last_q;

  always_comb begin
    s_valid_d   = s_valid_q;
    epoch_d     = epoch_q;
    answered_d  = answered_q;
    clr_d       = clr_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q;
    found_d     = found_q;
    dup_d       = dup_q;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    if (proceed) begin
      s_valid_d = 1'b0;
      if (!answered_q && s_range_q && seen) begin
        out_valid_d = 1'b1;
        found_d     = 1'b1;
        dup_d       = s_value_q;
        answered_d  = 1'b1;
      end
      if (s_last_q) begin
        if (!answered_d) begin
          out_valid_d = 1'b1;
          found_d     = 1'b0;
          dup_d       = '0;
        end
        answered_d = 1'b0;
        if (epoch_q == fdd_pkg::EPOCH_LAST) begin
          clr_d     = 1'b1;
          clr_cnt_d = '0;
          epoch_d   = fdd_pkg::EPOCH_FIRST;
        end else begin
          epoch_d = epoch_q + fdd_pkg::epoch_t'(1);
        end
      end
    end

    if (clr_q) begin
      clr_cnt_d = clr_cnt_q + addr_t'(1);
      if (clr_cnt_q == ADDR_END) begin
        clr_d = 1'b0;
      end
    end

    if (in_acc) begin
      s_valid_d = 1'b1;
    end
  end

  always_comb begin
    mem_we    = clr_q || mark_we;
    mem_waddr = clr_q ? clr_cnt_q : s_addr_q;
    mem_wdata = clr_q ? fdd_pkg::EPOCH_NONE : epoch_q;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (in_acc) begin
      rd_q <= mem[in_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s_last_q  <= last_i;
      s_range_q <= in_range;
      s_addr_q  <= in_addr;
      s_value_q <= value_i;
      fwd_q     <= mark_we && (s_addr_q == in_addr);
    end
    found_q <= found_d;
    dup_q   <= dup_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_valid_q   <= 1'b0;
      epoch_q     <= fdd_pkg::EPOCH_FIRST;
      answered_q  <= 1'b0;
      clr_q       <= 1'b1;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s_valid_q   <= s_valid_d;
      epoch_q     <= epoch_d;
      answered_q  <= answered_d;
      clr_q       <= clr_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign dup_value_o = dup_q;

endmodule
